// ===== sv/mmc_pkg.sv =====
package mmc_pkg;

  localparam int MAX_COLUMNS_DEF = 64;
  localparam int NPERM           = 24;
  localparam int ACC_W           = 48;

  // operand pairs fed to the shared multiplier
  typedef enum logic [3:0] {
    OP_NONE, OP_SASB, OP_SASA, OP_SBSB, OP_AB, OP_AA, OP_BB, OP_DOT,
    OP_SQHH, OP_SQHL, OP_SQLL, OP_VLL, OP_VLH, OP_VHL, OP_VHH
  } mul_op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_BASE, ST_BWAIT, ST_COMMIT, ST_NDOT, ST_NWAIT, ST_NABS, ST_NSQ,
    ST_NDRAIN, ST_D3LOAD, ST_DIV3, ST_NADD, ST_END, ST_FCHK, ST_VMUL, ST_VWAIT,
    ST_SQD_GO, ST_SQD_WAIT, ST_DVC_GO, ST_DVC_WAIT, ST_SQW_GO, ST_SQW_WAIT,
    ST_DVW_GO, ST_DVW_WAIT, ST_OUT
  } state_t;

  typedef struct packed {
    mul_op_t    op;
    logic [1:0] idx;
    logic [4:0] perm;
    logic       load;
    logic       commit;
    logic       take_abs;
    logic       d3_load;
    logic       d3_step;
    logic       nv_add;
    logic       count;
    logic       sq_start;
    logic       sq_sel;
    logic       take_d;
    logic       dv_start;
    logic       dv_sel;
    logic       take_cov;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic is_final;
    logic degen;
    logic sq_done;
    logic dv_done;
    logic out_free;
  } status_t;

  // letter of the second vector paired with letter i under permutation p
  function automatic logic [1:0] perm_letter(input logic [4:0] p, input logic [1:0] i);
    logic [7:0] code;
    case (p)
      5'd0:  code = 8'hE4;  5'd1:  code = 8'hB4;  5'd2:  code = 8'hD8;
      5'd3:  code = 8'h78;  5'd4:  code = 8'h9C;  5'd5:  code = 8'h6C;
      5'd6:  code = 8'hE1;  5'd7:  code = 8'hB1;  5'd8:  code = 8'hC9;
      5'd9:  code = 8'h39;  5'd10: code = 8'h8D;  5'd11: code = 8'h2D;
      5'd12: code = 8'hD2;  5'd13: code = 8'h72;  5'd14: code = 8'hC6;
      5'd15: code = 8'h36;  5'd16: code = 8'h4E;  5'd17: code = 8'h1E;
      5'd18: code = 8'h93;  5'd19: code = 8'h63;  5'd20: code = 8'h87;
      5'd21: code = 8'h27;  5'd22: code = 8'h4B;  5'd23: code = 8'h1B;
      default: code = 8'hE4;
    endcase
    return code[{i, 1'b0} +: 2];
  endfunction

endpackage

// ===== sv/motif_matrix_correlation.sv =====
// channel  | dir | signals                        | contents
// s_       | in  | tvalid tready tdata tlast      | one column of both matrices
// m_       | out | tvalid tready tdata tuser      | result of a matrix pair
// apb      | in  | psel penable pwrite paddr ...  | null_enable at byte address 0
//
// With null statistics on, each column also sends the 24 shuffled dot
// products and their squares through a single 24x24 multiplier, then a
// divide by three in four digits. Unless the pair is degenerate, the last
// column adds a 48-step square root and a 78-step divide, each run twice.
// Reset (rst, synchronous) clears the running accumulators.
// A waiting result does not block new columns; only the next final result
// waits for m_tready.
module motif_matrix_correlation #(
  parameter int MAX_COLUMNS = mmc_pkg::MAX_COLUMNS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,  // first_a0..a3, second_b0..b3, 16 bits each
  input  logic         s_tlast,  // last_column
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,  // correlation[31:0], null_mean[63:32], null_stdev[94:64]
  output logic [0:0]   m_tuser,  // degenerate
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import mmc_pkg::*;

  logic    null_enable;
  cmd_t    cmd;
  status_t status;

  // configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      null_enable <= 1'b1;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      null_enable <= pwdata[0];
    end
  end
  assign prdata = paddr[2] ? 32'd0 : {31'd0, null_enable};

  mmc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .null_enable(null_enable), .status(status), .cmd(cmd)
  );

  mmc_dp #(.MAX_COLUMNS(MAX_COLUMNS)) u_dp (
    .clk(clk), .rst(rst), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .cmd(cmd), .status(status), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser)
  );
endmodule

// ===== sv/mmc_sqrt.sv =====
module mmc_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [95:0] radicand,
  output logic [47:0] root,
  output logic        done
);
  logic        busy;
  logic [5:0]  cnt;
  logic [95:0] rad;
  logic [49:0] rem;
  logic [51:0] t;
  logic [51:0] trial;

  // one result bit per cycle, two radicand bits in
  assign t     = {rem, rad[95:94]};
  assign trial = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 6'd47);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd47) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[93:0], 2'b00};
      if (t >= trial) begin
        rem  <= 50'(t - trial);
        root <= {root[46:0], 1'b1};
      end else begin
        rem  <= t[49:0];
        root <= {root[46:0], 1'b0};
      end
    end
  end
endmodule

// ===== sv/mmc_div.sv =====
module mmc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] num,
  input  logic [47:0] den,
  output logic [32:0] quot,
  output logic        done
);
  localparam logic [33:0] QCAP = 34'h1_0000_0000;

  logic        busy;
  logic [6:0]  cnt;
  logic [77:0] sh;
  logic [47:0] r;
  logic [47:0] d;
  logic [33:0] q;
  logic [33:0] qs;
  logic [48:0] rt;

  // restoring divide of num * 2^30, quotient held at 2^32
  assign rt   = {r, sh[77]};
  assign qs   = (q < QCAP) ? {q[32:0], 1'b0} : q;
  assign quot = (q > QCAP) ? QCAP[32:0] : q[32:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 7'd77);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'd77) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh <= {num, 30'd0};
      r  <= '0;
      q  <= '0;
      d  <= den;
    end else if (busy) begin
      sh <= {sh[76:0], 1'b0};
      if (rt >= {1'b0, d}) begin
        r <= 48'(rt - {1'b0, d});
        q <= (qs < QCAP) ? (qs | 34'd1) : qs;
      end else begin
        r <= rt[47:0];
        q <= qs;
      end
    end
  end
endmodule

// ===== sv/mmc_dp.sv =====
module mmc_dp #(
  parameter int MAX_COLUMNS = mmc_pkg::MAX_COLUMNS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [127:0]     s_tdata,
  input  logic             s_tlast,
  input  mmc_pkg::cmd_t    cmd,
  output mmc_pkg::status_t status,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [95:0]      m_tdata,
  output logic [0:0]       m_tuser
);
  import mmc_pkg::*;

  localparam int CNT_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  logic [15:0] a [4];
  logic [15:0] b [4];
  logic        last_q;
  logic [17:0] sa, sb;
  logic [CNT_W-1:0] col_cnt;

  logic [23:0] mx, my;
  logic [47:0] prod;
  mul_op_t     op_q;
  logic [1:0]  idx_q;
  logic [1:0]  bsel;

  logic [35:0] sasb, sasa, sbsb;
  logic [33:0] dot0, sqa, sqb, dotp;
  logic [35:0] u;
  logic [76:0] ssum;
  logic [95:0] pv;

  logic signed [47:0] cov_acc, va_acc, vb_acc;
  logic [47:0] nv_acc;

  logic [43:0] q3;
  logic [1:0]  r3;
  logic [12:0] t3;
  logic [26:0] t3_scaled;
  logic [10:0] q3_digit;

  logic [47:0] d_reg, d_fix, cov_mag;
  logic [31:0] corr_q;
  logic [30:0] stdev;

  logic [95:0] sq_rad;
  logic [47:0] sq_root;
  logic [47:0] dv_num, dv_den;
  logic [32:0] dv_q;
  logic        sq_done, dv_done;

  logic signed [37:0] cov_col, va_col, vb_col, c_perm;
  logic [48:0] nv_sum;

  function automatic logic signed [47:0] sat48(input logic signed [47:0] acc,
                                               input logic signed [37:0] d);
    logic signed [48:0] s;
    s = {acc[47], acc} + {{11{d[37]}}, d};
    if (s[48] != s[47]) sat48 = s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    else sat48 = s[47:0];
    return sat48;
  endfunction

  // operand select for the shared multiplier
  assign bsel = (cmd.op == OP_DOT) ? perm_letter(cmd.perm, cmd.idx) : cmd.idx;

  always_comb begin
    mx = '0;
    my = '0;
    case (cmd.op)
      OP_SASB: begin mx = 24'(sa); my = 24'(sb); end
      OP_SASA: begin mx = 24'(sa); my = 24'(sa); end
      OP_SBSB: begin mx = 24'(sb); my = 24'(sb); end
      OP_AB:   begin mx = 24'(a[cmd.idx]); my = 24'(b[bsel]); end
      OP_AA:   begin mx = 24'(a[cmd.idx]); my = 24'(a[cmd.idx]); end
      OP_BB:   begin mx = 24'(b[bsel]); my = 24'(b[bsel]); end
      OP_DOT:  begin mx = 24'(a[cmd.idx]); my = 24'(b[bsel]); end
      OP_SQHH: begin mx = 24'(u[35:18]); my = 24'(u[35:18]); end
      OP_SQHL: begin mx = 24'(u[35:18]); my = 24'(u[17:0]); end
      OP_SQLL: begin mx = 24'(u[17:0]); my = 24'(u[17:0]); end
      OP_VLL:  begin mx = va_acc[23:0]; my = vb_acc[23:0]; end
      OP_VLH:  begin mx = va_acc[23:0]; my = vb_acc[47:24]; end
      OP_VHL:  begin mx = va_acc[47:24]; my = vb_acc[23:0]; end
      OP_VHH:  begin mx = va_acc[47:24]; my = vb_acc[47:24]; end
      default: begin mx = '0; my = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod  <= mx * my;
    op_q  <= cmd.op;
    idx_q <= cmd.idx;
  end

  // per-column forms: n*sum(xy) - sum(x)*sum(y) with n = 4
  assign cov_col   = $signed({2'b00, dot0, 2'b00}) - $signed({2'b00, sasb});
  assign va_col    = $signed({2'b00, sqa, 2'b00}) - $signed({2'b00, sasa});
  assign vb_col    = $signed({2'b00, sqb, 2'b00}) - $signed({2'b00, sbsb});
  assign c_perm    = $signed({2'b00, dotp, 2'b00}) - $signed({2'b00, sasb});
  assign t3        = {r3, q3[43:33]};
  assign t3_scaled = 27'(t3) * 27'd10923;
  assign q3_digit  = t3_scaled[25:15];
  assign nv_sum    = {1'b0, nv_acc} + {5'd0, q3};

  // input latch and product accumulation
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 4; i++) begin
        a[i] <= s_tdata[16*i +: 16];
        b[i] <= s_tdata[64 + 16*i +: 16];
      end
      last_q <= s_tlast;
      sa   <= 18'(s_tdata[15:0]) + 18'(s_tdata[31:16])
            + 18'(s_tdata[47:32]) + 18'(s_tdata[63:48]);
      sb   <= 18'(s_tdata[79:64]) + 18'(s_tdata[95:80])
            + 18'(s_tdata[111:96]) + 18'(s_tdata[127:112]);
      dot0 <= '0;
      sqa  <= '0;
      sqb  <= '0;
      ssum <= '0;
    end else begin
      case (op_q)
        OP_SASB: sasb <= prod[35:0];
        OP_SASA: sasa <= prod[35:0];
        OP_SBSB: sbsb <= prod[35:0];
        OP_AB:   dot0 <= dot0 + prod[33:0];
        OP_AA:   sqa  <= sqa + prod[33:0];
        OP_BB:   sqb  <= sqb + prod[33:0];
        OP_DOT:  dotp <= (idx_q == 2'd0) ? prod[33:0] : dotp + prod[33:0];
        OP_SQHH: ssum <= ssum + ({41'd0, prod[35:0]} << 36);
        OP_SQHL: ssum <= ssum + ({41'd0, prod[35:0]} << 19);
        OP_SQLL: ssum <= ssum + {41'd0, prod[35:0]};
        OP_VLL:  pv   <= {48'd0, prod};
        OP_VLH:  pv   <= pv + ({48'd0, prod} << 24);
        OP_VHL:  pv   <= pv + ({48'd0, prod} << 24);
        OP_VHH:  pv   <= pv + ({48'd0, prod} << 48);
        default: ;
      endcase
    end
    if (cmd.take_abs) u <= c_perm[37] ? 36'(-c_perm) : c_perm[35:0];
  end

  // divide the scaled second moment by three, one 11-bit digit a step;
  // each digit comes from a reciprocal multiply of remainder and digit
  always_ff @(posedge clk) begin
    if (cmd.d3_load) begin
      q3 <= ssum[76:33];
      r3 <= '0;
    end else if (cmd.d3_step) begin
      r3 <= 2'(t3 - {q3_digit, 1'b0} - {2'b00, q3_digit});
      q3 <= {q3[32:0], q3_digit};
    end
  end

  // running accumulators
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      cov_acc <= '0;
      va_acc  <= '0;
      vb_acc  <= '0;
      nv_acc  <= '0;
      col_cnt <= '0;
    end else begin
      if (cmd.commit) begin
        cov_acc <= sat48(cov_acc, cov_col);
        va_acc  <= sat48(va_acc, va_col);
        vb_acc  <= sat48(vb_acc, vb_col);
      end
      if (cmd.nv_add) nv_acc <= nv_sum[48] ? {48{1'b1}} : nv_sum[47:0];
      if (cmd.count) col_cnt <= col_cnt + 1'b1;
    end
  end

  // root and quotient units
  assign sq_rad  = cmd.sq_sel ? {18'd0, nv_acc, 30'd0} : pv;
  assign d_fix   = (sq_root == '0) ? 48'd1 : sq_root;
  assign cov_mag = cov_acc[47] ? 48'(-cov_acc) : cov_acc;
  assign dv_num  = cmd.dv_sel ? sq_root : cov_mag;
  assign dv_den  = cmd.dv_sel ? d_reg : d_fix;

  mmc_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(cmd.sq_start), .radicand(sq_rad),
    .root(sq_root), .done(sq_done)
  );

  mmc_div u_div (
    .clk(clk), .rst(rst), .start(cmd.dv_start), .num(dv_num), .den(dv_den),
    .quot(dv_q), .done(dv_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.take_d) d_reg <= d_fix;
    if (cmd.take_cov) begin
      if (cov_acc[47])
        corr_q <= (dv_q > 33'h0_8000_0000) ? 32'h8000_0000 : 32'(-dv_q);
      else
        corr_q <= (dv_q > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : dv_q[31:0];
    end
  end

  assign stdev = (dv_q > 33'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : dv_q[30:0];

  // output register; the shuffled mean is zero for any inputs
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tdata <= status.degen ? '0 : {1'b0, stdev, 32'd0, corr_q};
      m_tuser <= status.degen;
    end
  end

  assign status.is_final = last_q || (col_cnt == CNT_W'(MAX_COLUMNS - 1));
  assign status.degen    = va_acc[47] || (va_acc == '0) || vb_acc[47] || (vb_acc == '0);
  assign status.sq_done  = sq_done;
  assign status.dv_done  = dv_done;
  assign status.out_free = !m_tvalid || m_tready;
endmodule

// ===== sv/mmc_ctrl.sv =====
module mmc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic             null_enable,
  input  mmc_pkg::status_t status,
  output mmc_pkg::cmd_t    cmd
);
  import mmc_pkg::*;

  state_t     state, state_next;
  logic [5:0] step, step_next;
  logic [4:0] perm, perm_next;
  logic [5:0] base_off;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
      perm  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      perm  <= perm_next;
    end
  end

  assign base_off = step - 6'd3;

  always_comb begin
    state_next = state;
    step_next  = step;
    perm_next  = perm;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_BASE;
          step_next  = '0;
        end
      end
      // sums of products for the unshuffled column
      ST_BASE: begin
        cmd.idx = base_off[1:0];
        if (step == 6'd0)      cmd.op = OP_SASB;
        else if (step == 6'd1) cmd.op = OP_SASA;
        else if (step == 6'd2) cmd.op = OP_SBSB;
        else if (step < 6'd7)  cmd.op = OP_AB;
        else if (step < 6'd11) cmd.op = OP_AA;
        else                   cmd.op = OP_BB;
        step_next = step + 6'd1;
        if (step == 6'd14) state_next = ST_BWAIT;
      end
      ST_BWAIT: state_next = ST_COMMIT;
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        step_next  = '0;
        perm_next  = '0;
        state_next = null_enable ? ST_NDOT : ST_END;
      end
      // one shuffled dot product, then its square in three pieces
      ST_NDOT: begin
        cmd.op    = OP_DOT;
        cmd.idx   = step[1:0];
        cmd.perm  = perm;
        step_next = step + 6'd1;
        if (step == 6'd3) state_next = ST_NWAIT;
      end
      ST_NWAIT: state_next = ST_NABS;
      ST_NABS: begin
        cmd.take_abs = 1'b1;
        step_next    = '0;
        state_next   = ST_NSQ;
      end
      ST_NSQ: begin
        if (step == 6'd0)      cmd.op = OP_SQHH;
        else if (step == 6'd1) cmd.op = OP_SQHL;
        else                   cmd.op = OP_SQLL;
        step_next = step + 6'd1;
        if (step == 6'd2) begin
          step_next = '0;
          if (perm == 5'(NPERM - 1)) begin
            state_next = ST_NDRAIN;
          end else begin
            perm_next  = perm + 5'd1;
            state_next = ST_NDOT;
          end
        end
      end
      ST_NDRAIN: state_next = ST_D3LOAD;
      ST_D3LOAD: begin
        cmd.d3_load = 1'b1;
        step_next   = '0;
        state_next  = ST_DIV3;
      end
      // four 11-bit digits of the divide by three
      ST_DIV3: begin
        cmd.d3_step = 1'b1;
        step_next   = step + 6'd1;
        if (step == 6'd3) state_next = ST_NADD;
      end
      ST_NADD: begin
        cmd.nv_add = 1'b1;
        state_next = ST_END;
      end
      ST_END: begin
        if (status.is_final) begin
          state_next = ST_FCHK;
        end else begin
          cmd.count  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_FCHK: begin
        step_next  = '0;
        state_next = status.degen ? ST_OUT : ST_VMUL;
      end
      // 96-bit variance product from four partial products
      ST_VMUL: begin
        if (step == 6'd0)      cmd.op = OP_VLL;
        else if (step == 6'd1) cmd.op = OP_VLH;
        else if (step == 6'd2) cmd.op = OP_VHL;
        else                   cmd.op = OP_VHH;
        step_next = step + 6'd1;
        if (step == 6'd3) state_next = ST_VWAIT;
      end
      ST_VWAIT: state_next = ST_SQD_GO;
      ST_SQD_GO: begin
        cmd.sq_start = 1'b1;
        state_next   = ST_SQD_WAIT;
      end
      ST_SQD_WAIT: if (status.sq_done) state_next = ST_DVC_GO;
      ST_DVC_GO: begin
        cmd.take_d   = 1'b1;
        cmd.dv_start = 1'b1;
        state_next   = ST_DVC_WAIT;
      end
      ST_DVC_WAIT: if (status.dv_done) state_next = ST_SQW_GO;
      ST_SQW_GO: begin
        cmd.take_cov = 1'b1;
        cmd.sq_start = 1'b1;
        cmd.sq_sel   = 1'b1;
        state_next   = ST_SQW_WAIT;
      end
      ST_SQW_WAIT: if (status.sq_done) state_next = ST_DVW_GO;
      ST_DVW_GO: begin
        cmd.dv_start = 1'b1;
        cmd.dv_sel   = 1'b1;
        state_next   = ST_DVW_WAIT;
      end
      ST_DVW_WAIT: if (status.dv_done) state_next = ST_OUT;
      ST_OUT: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// ===== sv/mmc_checker.sv =====
module mmc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata,
  input logic [0:0]  m_tuser
);
  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // degenerate pairs give all-zero statistics
  a_degen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == 96'd0)
    else $error("degenerate result not zero");

  // shuffled mean is zero and the pad bit stays clear
  a_mean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[63:32] == 32'd0) && !m_tdata[95])
    else $error("null mean or pad bit set");
endmodule

bind motif_matrix_correlation mmc_checker u_mmc_checker (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata), .m_tuser(m_tuser)
);
